/* hdl/mrrp_pkg.sv */
// Package for the Modbus read response parser: word types, constants, CRC step.
`timescale 1ns / 1ps
package mrrp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [8:0]  MIN_FRAME       = 9'd5;
  localparam logic [8:0]  POS_MAX         = 9'd511;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
  localparam logic [6:0] REG_LIMIT_RST  = 7'd127;

  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_REG_LIMIT  = 1'b1;

  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_FUNCTION = 3'd3,
    ST_ODD      = 3'd4,
    ST_BAD      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] register_value;
    logic [6:0]  register_index;
    logic [2:0]  status;
    logic [6:0]  register_count;
    logic        last_of_item;
  } out_word_t;

  typedef struct packed {
    logic [8:0]  pos;
    logic [7:0]  data_cnt;
    logic        addr_ok;
    logic        func_ok;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [7:0]  hi_hold;
    logic [6:0]  words;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    pos:      9'd0,
    data_cnt: 8'd0,
    addr_ok:  1'b0,
    func_ok:  1'b0,
    crc:      CRC_INIT,
    rx_crc:   16'd0,
    hi_hold:  8'd0,
    words:    7'd0
  };

  // CRC-16/Modbus, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/mrrp_parse.sv */
// Per-byte frame parsing: next frame state and up to two result words.
`timescale 1ns / 1ps
module mrrp_parse (
  input  mrrp_pkg::frame_state_t state_i,
  input  mrrp_pkg::in_word_t     in_word_i,
  input  logic [7:0]             slave_addr_i,
  input  logic [6:0]             reg_limit_i,
  output mrrp_pkg::frame_state_t state_o,
  output mrrp_pkg::out_word_t    res0_o,
  output mrrp_pkg::out_word_t    res1_o,
  output logic [1:0]             push_n_o
);
  import mrrp_pkg::*;

  logic [7:0]   b;
  logic [8:0]   data_end;
  logic         word_emit;
  frame_state_t upd;
  status_e      status;
  logic [6:0]   half_cnt;
  logic [6:0]   count;
  out_word_t    word_res;
  out_word_t    verdict_res;

  assign b        = in_word_i.rx_byte;
  assign data_end = 9'd3 + {1'b0, state_i.data_cnt};

  always_comb begin
    upd       = state_i;
    word_emit = 1'b0;
    if (state_i.pos == 9'd0) begin
      upd.addr_ok = (b == slave_addr_i);
      upd.crc     = crc_byte(state_i.crc, b);
    end else if (state_i.pos == 9'd1) begin
      upd.func_ok = (b == FC_READ_HOLDING);
      upd.crc     = crc_byte(state_i.crc, b);
    end else if (state_i.pos == 9'd2) begin
      upd.data_cnt = b;
      upd.crc      = crc_byte(state_i.crc, b);
    end else if (state_i.pos < data_end) begin
      upd.crc = crc_byte(state_i.crc, b);
      // data bytes start at position 3: odd position is a high byte
      if (state_i.pos[0]) begin
        upd.hi_hold = b;
      end else if (state_i.words < reg_limit_i) begin
        word_emit = 1'b1;
        upd.words = state_i.words + 7'd1;
      end
    end else if (state_i.pos == data_end) begin
      upd.rx_crc = {state_i.rx_crc[15:8], b};
    end else if (state_i.pos == data_end + 9'd1) begin
      upd.rx_crc = {b, state_i.rx_crc[7:0]};
    end
    if (state_i.pos < POS_MAX) begin
      upd.pos = state_i.pos + 9'd1;
    end
  end

  assign half_cnt = upd.data_cnt[7:1];
  assign count    = (half_cnt > reg_limit_i) ? reg_limit_i : half_cnt;

  always_comb begin
    if (upd.pos < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (!upd.addr_ok) begin
      status = ST_ADDRESS;
    end else if (!upd.func_ok) begin
      status = ST_FUNCTION;
    end else if (upd.data_cnt[0]) begin
      status = ST_ODD;
    end else if (upd.pos < MIN_FRAME + {1'b0, upd.data_cnt}) begin
      status = ST_BAD;
    end else if (upd.crc != upd.rx_crc) begin
      status = ST_BAD;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    word_res                = '0;
    word_res.kind           = KIND_WORD;
    word_res.register_value = {state_i.hi_hold, b};
    word_res.register_index = state_i.words;
    word_res.last_of_item   = !in_word_i.frame_end;

    verdict_res                = '0;
    verdict_res.kind           = KIND_VERDICT;
    verdict_res.status         = status;
    verdict_res.register_count = (status == ST_OK) ? count : 7'd0;
    verdict_res.last_of_item   = 1'b1;
  end

  always_comb begin
    res1_o = verdict_res;
    if (word_emit) begin
      res0_o   = word_res;
      push_n_o = in_word_i.frame_end ? 2'd2 : 2'd1;
    end else begin
      res0_o   = verdict_res;
      push_n_o = in_word_i.frame_end ? 2'd1 : 2'd0;
    end
    state_o = in_word_i.frame_end ? FRAME_CLEAR : upd;
  end

endmodule

/* hdl/mrrp_out_fifo.sv */
// Result queue: takes up to two words per cycle, delivers one per cycle while out_stall_i is low.
`timescale 1ns / 1ps
module mrrp_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_n_i,
  input  mrrp_pkg::out_word_t           wr0_i,
  input  mrrp_pkg::out_word_t           wr1_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrrp_pkg::out_word_t           out_word_o,
  output logic [mrrp_pkg::LEVEL_W-1:0]  level_o
);
  import mrrp_pkg::*;

  out_word_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [FIFO_AW-1:0]   wr_ptr_nx;
  logic                 pop;

  assign out_valid_o = (level_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign level_o     = level_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + FIFO_AW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_n_i);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
    level_d  = level_q + LEVEL_W'(push_n_i) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= wr1_i;
    end
  end

endmodule

/* hdl/modbus_read_response_parser_core.sv */
// Modbus RTU read-holding-registers response parser, top level.
// Each byte's result words enter a four-entry result queue when it is accepted.
// Throughput: one byte per cycle unless in_stall_o; a byte may yield two words
// (last data word plus verdict), drained one per cycle unless out_stall_i.
// Reset: asynchronous, active low; clears frame state and queue, slave
// address to 1 and register limit to 127.
`timescale 1ns / 1ps
module modbus_read_response_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrrp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrrp_pkg::out_word_t out_word_o
);
  import mrrp_pkg::*;

  logic [7:0]         slave_addr_q;
  logic [6:0]         reg_limit_q;
  frame_state_t       state_q, state_d;
  frame_state_t       state_nx;
  out_word_t          res0, res1;
  logic [1:0]         push_n_raw;
  logic [1:0]         push_n;
  logic               in_acc;
  logic [LEVEL_W-1:0] level;

  assign in_stall_o = (level > LEVEL_W'(FIFO_DEPTH - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push_n     = in_acc ? push_n_raw : 2'd0;
  assign state_d    = in_acc ? state_nx : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RST;
      reg_limit_q  <= REG_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i;
        CFG_REG_LIMIT:  reg_limit_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRAME_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  mrrp_parse u_parse (
    .state_i      (state_q),
    .in_word_i    (in_word_i),
    .slave_addr_i (slave_addr_q),
    .reg_limit_i  (reg_limit_q),
    .state_o      (state_nx),
    .res0_o       (res0),
    .res1_o       (res1),
    .push_n_o     (push_n_raw)
  );

  mrrp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .wr0_i       (res0),
    .wr1_i       (res1),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .level_o     (level)
  );

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_verdict_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.frame_end) |=> out_valid_o)
    else $error("frame end accepted but no result queued");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.frame_end) |=> (state_q.pos == 9'd0 && state_q.words == 7'd0))
    else $error("frame state not cleared after verdict");
`endif

endmodule
